[hw/rtl/clnw_pkg.sv]
// Shared types, constants and helpers for the character LCD nibble writer.
// Used by clnw_seq and char_lcd_nibble_writer_core; depends on nothing.
package clnw_pkg;

  // Width of the strobe tick counter.
  localparam int STROBE_COUNT_BITS = 10;
  // Width of the strobe length register.
  localparam int STROBE_W = 10;
  // Reset value of the strobe length register.
  localparam logic [STROBE_W-1:0] STROBE_RESET = STROBE_W'(50);
  // Working width for the length clamp, wider than the strobe register and counter.
  localparam int WIDE_W = 17;
  localparam logic [WIDE_W-1:0] MAX_COUNT = WIDE_W'((1 << STROBE_COUNT_BITS) - 1);

  // Busy flag position in the status byte.
  localparam logic [7:0] BUSY_BIT = 8'h80;

  // Packed widths of the stream payloads.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_RD1_HI = 9'b000000010,
    PH_RD1_LO = 9'b000000100,
    PH_RD2_HI = 9'b000001000,
    PH_RD2_LO = 9'b000010000,
    PH_WRH_HI = 9'b000100000,
    PH_WRH_LO = 9'b001000000,
    PH_WRL_HI = 9'b010000000,
    PH_WRL_LO = 9'b100000000
  } phase_t;

  // One tick's worth of input.
  typedef struct packed {
    logic       req_valid;
    logic [7:0] req_byte;
    logic       req_rs;
    logic       req_low_only;
    logic [3:0] pin_data;
  } tick_in_t;

  // Pin levels and status for one tick.
  typedef struct packed {
    logic       lcd_e;
    logic       lcd_rs;
    logic       lcd_rw;
    logic [3:0] bus_out;
    logic       bus_drive;
    logic       ready_res;
    logic       done_res;
  } pins_t;

  // Strobe period in ticks: zero counts as one, clamped to the counter range.
  function automatic logic [STROBE_COUNT_BITS-1:0] period_len(
    input logic [STROBE_W-1:0] st
  );
    logic [WIDE_W-1:0] n;
    n = WIDE_W'(st);
    if (n == '0) n = WIDE_W'(1);
    if (n > MAX_COUNT) n = MAX_COUNT;
    return n[STROBE_COUNT_BITS-1:0];
  endfunction

endpackage

[hw/rtl/clnw_seq.sv]
// Pin-level sequencer state for the character LCD nibble writer.
// Depends on clnw_pkg; advances one tick per asserted advance.
module clnw_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [clnw_pkg::STROBE_W-1:0]   strobe_ticks,
  input  clnw_pkg::tick_in_t              tick_in,
  output clnw_pkg::pins_t                 pins
);

  clnw_pkg::phase_t phase, phase_next;
  logic [clnw_pkg::STROBE_COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_rs, held_rs_next;
  logic       held_low_only, held_low_only_next;
  logic       busy_seen, busy_seen_next;

  logic [clnw_pkg::STROBE_COUNT_BITS-1:0] plen;
  logic                                   last;

  assign plen = clnw_pkg::period_len(strobe_ticks);
  assign last = ({1'b0, tick_count} + 1'b1) >= {1'b0, plen};

  // Pin levels come from the state before this tick's update.
  always_comb begin
    pins = '0;
    pins.bus_drive = 1'b1;
    case (phase)
      clnw_pkg::PH_IDLE: begin
        pins.ready_res = 1'b1;
      end
      clnw_pkg::PH_RD1_HI, clnw_pkg::PH_RD2_HI: begin
        pins.lcd_e     = 1'b1;
        pins.lcd_rw    = 1'b1;
        pins.bus_drive = 1'b0;
      end
      clnw_pkg::PH_RD1_LO, clnw_pkg::PH_RD2_LO: begin
        pins.lcd_rw    = 1'b1;
        pins.bus_drive = 1'b0;
      end
      clnw_pkg::PH_WRH_HI, clnw_pkg::PH_WRH_LO: begin
        pins.lcd_e   = (phase == clnw_pkg::PH_WRH_HI);
        pins.lcd_rs  = held_rs;
        pins.bus_out = held_byte[7:4];
      end
      clnw_pkg::PH_WRL_HI, clnw_pkg::PH_WRL_LO: begin
        pins.lcd_e    = (phase == clnw_pkg::PH_WRL_HI);
        pins.lcd_rs   = held_rs;
        pins.bus_out  = held_byte[3:0];
        pins.done_res = (phase == clnw_pkg::PH_WRL_LO) && last;
      end
      default: begin
        pins.ready_res = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    held_byte_next     = held_byte;
    held_rs_next       = held_rs;
    held_low_only_next = held_low_only;
    busy_seen_next     = busy_seen;
    if (phase == clnw_pkg::PH_IDLE) begin
      if (tick_in.req_valid) begin
        held_byte_next     = tick_in.req_byte;
        held_rs_next       = tick_in.req_rs;
        held_low_only_next = tick_in.req_low_only;
        busy_seen_next     = 1'b0;
        tick_count_next    = '0;
        phase_next         = clnw_pkg::PH_RD1_HI;
      end
    end else if (!last) begin
      tick_count_next = tick_count + 1'b1;
    end else begin
      tick_count_next = '0;
      case (phase)
        clnw_pkg::PH_RD1_HI: begin
          // The status nibble carries bit 7 of the status byte in its top bit.
          busy_seen_next = (({tick_in.pin_data, 4'b0000} & clnw_pkg::BUSY_BIT) != 8'h00);
          phase_next     = clnw_pkg::PH_RD1_LO;
        end
        clnw_pkg::PH_RD1_LO: phase_next = clnw_pkg::PH_RD2_HI;
        clnw_pkg::PH_RD2_HI: phase_next = clnw_pkg::PH_RD2_LO;
        clnw_pkg::PH_RD2_LO: begin
          if (busy_seen) begin
            phase_next = clnw_pkg::PH_RD1_HI;
          end else if (held_low_only) begin
            phase_next = clnw_pkg::PH_WRL_HI;
          end else begin
            phase_next = clnw_pkg::PH_WRH_HI;
          end
        end
        clnw_pkg::PH_WRH_HI: phase_next = clnw_pkg::PH_WRH_LO;
        clnw_pkg::PH_WRH_LO: phase_next = clnw_pkg::PH_WRL_HI;
        clnw_pkg::PH_WRL_HI: phase_next = clnw_pkg::PH_WRL_LO;
        default:             phase_next = clnw_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= clnw_pkg::PH_IDLE;
      tick_count    <= '0;
      held_byte     <= '0;
      held_rs       <= 1'b0;
      held_low_only <= 1'b0;
      busy_seen     <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      held_byte     <= held_byte_next;
      held_rs       <= held_rs_next;
      held_low_only <= held_low_only_next;
      busy_seen     <= busy_seen_next;
    end
  end

  // While idle the pins rest: no strobe, write direction, bus driven.
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    pins.ready_res |-> !pins.lcd_e && !pins.lcd_rw && pins.bus_drive)
    else $error("idle pins not at rest");

  // The bus is released only for reads, and then shows zero.
  a_release_read: assert property (@(posedge clk) disable iff (rst)
    !pins.bus_drive |-> pins.lcd_rw && (pins.bus_out == 4'h0))
    else $error("bus released outside a read");

  // Completion only on the low nibble's closing phase.
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    pins.done_res |-> (phase == clnw_pkg::PH_WRL_LO) && last)
    else $error("done outside final write phase");

  // An accepted request always starts with a busy poll.
  a_start_poll: assert property (@(posedge clk) disable iff (rst)
    advance && (phase == clnw_pkg::PH_IDLE) && tick_in.req_valid
    |=> (phase == clnw_pkg::PH_RD1_HI) && (tick_count == '0))
    else $error("request did not start a busy poll");

endmodule

[hw/rtl/char_lcd_nibble_writer_core.sv]
// Top level of the character LCD nibble writer: stream ports, strobe length
// register and result register. Depends on clnw_pkg and clnw_seq.
//
// This block drives a character LCD on a 4-bit bus at pin level. Every input
// transfer is one tick of the bus sequencer and yields exactly one output
// transfer holding the pin levels and status of that tick; one transfer is
// taken per clock cycle whenever the output side keeps up, and each output
// transfer is offered from the result register in the cycle after its input
// transfer. A write request (req_valid set while ready_res was high)
// first polls the busy flag with two read strobes (RW high, RS low, bus
// released, D7 sampled on the last E-high tick of the first strobe), repeats
// the poll while busy, and then writes the high and low nibbles, or only the
// low nibble when req_low_only is set. Each strobe is E high for strobe_ticks
// ticks followed by E low for strobe_ticks ticks; a zero length counts as
// one. The strobe length register is written through the cfg channel, which
// is always ready. A new length applies from the next tick on, even in the
// middle of a strobe; a count already at or past the new length ends the
// running period on that tick.
module char_lcd_nibble_writer_core (
  input  logic                                clk,
  input  logic                                rst,
  // Input tick stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] req_valid, [8:1] req_byte, [9] req_low_only, [13:10] pin_data, [15:14] zero
  input  logic [clnw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] req_rs
  input  logic                                s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] lcd_e, [1] lcd_rs, [2] lcd_rw, [6:3] bus_out, [7] bus_drive,
  // [8] ready_res, [9] done_res, [15:10] zero
  output logic [clnw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // Strobe length register write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clnw_pkg::STROBE_W-1:0]       cfg_data
);

  logic [clnw_pkg::STROBE_W-1:0] strobe_ticks;
  logic                          in_xfer;
  clnw_pkg::tick_in_t            tick_in;
  clnw_pkg::pins_t               pins;

  // The result register frees up whenever its content is taken, so a new
  // tick is accepted in the same cycle the previous result leaves.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Unpack the input transfer.
  assign tick_in.req_valid    = s_axis_tdata[0];
  assign tick_in.req_byte     = s_axis_tdata[8:1];
  assign tick_in.req_low_only = s_axis_tdata[9];
  assign tick_in.pin_data     = s_axis_tdata[13:10];
  assign tick_in.req_rs       = s_axis_tuser;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_ticks <= clnw_pkg::STROBE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      strobe_ticks <= cfg_data;
    end
  end

  // The sequencer only moves when a tick transfer is accepted.
  clnw_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_xfer),
    .strobe_ticks (strobe_ticks),
    .tick_in      (tick_in),
    .pins         (pins)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_axis_tdata <= {6'b000000, pins.done_res, pins.ready_res, pins.bus_drive,
                       pins.bus_out, pins.lcd_rw, pins.lcd_rs, pins.lcd_e};
    end
  end

  // Each accepted tick produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // A waiting result blocks new ticks so none is overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted over a waiting result");

  // Done and ready never appear together in one result.
  a_done_not_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[8]))
    else $error("done and ready both set");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for char_lcd_nibble_writer_core: drives pin-level ticks
// into the stream port and compares every result transfer with a tick-by-tick
// prediction of the LCD bus sequencer. Depends on clnw_pkg and the core RTL.
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int IDLE_PCT    = 38;

  // Predicts the pin levels of every tick and keeps them until the core
  // delivers the matching result transfer.
  class lcd_pin_scoreboard;
    logic [clnw_pkg::STROBE_W-1:0]          strobe_len;
    clnw_pkg::phase_t                       seq_phase;
    logic [clnw_pkg::STROBE_COUNT_BITS-1:0] tick_cnt;
    logic [7:0]                             cur_byte;
    logic                                   cur_rs;
    logic                                   cur_low_only;
    logic                                   busy_flag;
    clnw_pkg::pins_t                        pin_levels_q[$];
    int                                     failures;
    int                                     ticks_seen;
    int                                     writes_done;
    int                                     busy_polls;

    function new();
      strobe_len   = clnw_pkg::STROBE_RESET;
      seq_phase    = clnw_pkg::PH_IDLE;
      tick_cnt     = '0;
      cur_byte     = '0;
      cur_rs       = 1'b0;
      cur_low_only = 1'b0;
      busy_flag    = 1'b0;
      failures     = 0;
      ticks_seen   = 0;
      writes_done  = 0;
      busy_polls   = 0;
    endfunction

    function void set_strobe(logic [clnw_pkg::STROBE_W-1:0] v);
      strobe_len = v;
    endfunction

    function int pending();
      return pin_levels_q.size();
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Zero counts as one tick; longer than the counter can hold is clamped.
    function int unsigned strobe_period();
      int unsigned n;
      int unsigned top;
      top = (32'd1 << clnw_pkg::STROBE_COUNT_BITS) - 32'd1;
      n = 32'(strobe_len);
      if (n == 0) n = 1;
      if (n > top) n = top;
      return n;
    endfunction

    // One accepted tick: record the pin levels it produces, then advance.
    function void note_input(clnw_pkg::tick_in_t t);
      clnw_pkg::pins_t p;
      logic            last;
      last = (32'(tick_cnt) + 32'd1) >= strobe_period();
      p = '0;
      p.bus_drive = 1'b1;
      case (seq_phase)
        clnw_pkg::PH_IDLE: p.ready_res = 1'b1;
        clnw_pkg::PH_RD1_HI, clnw_pkg::PH_RD2_HI: begin
          p.lcd_e = 1'b1;
          p.lcd_rw = 1'b1;
          p.bus_drive = 1'b0;
        end
        clnw_pkg::PH_RD1_LO, clnw_pkg::PH_RD2_LO: begin
          p.lcd_rw = 1'b1;
          p.bus_drive = 1'b0;
        end
        clnw_pkg::PH_WRH_HI, clnw_pkg::PH_WRH_LO: begin
          p.lcd_e = (seq_phase == clnw_pkg::PH_WRH_HI);
          p.lcd_rs = cur_rs;
          p.bus_out = cur_byte[7:4];
        end
        default: begin
          p.lcd_e = (seq_phase == clnw_pkg::PH_WRL_HI);
          p.lcd_rs = cur_rs;
          p.bus_out = cur_byte[3:0];
          p.done_res = (seq_phase == clnw_pkg::PH_WRL_LO) && last;
        end
      endcase
      pin_levels_q.push_back(p);
      ticks_seen++;
      if (p.done_res) writes_done++;

      if (seq_phase == clnw_pkg::PH_IDLE) begin
        if (t.req_valid) begin
          cur_byte = t.req_byte;
          cur_rs = t.req_rs;
          cur_low_only = t.req_low_only;
          busy_flag = 1'b0;
          tick_cnt = '0;
          seq_phase = clnw_pkg::PH_RD1_HI;
        end
      end else if (!last) begin
        tick_cnt = tick_cnt + 1'b1;
      end else begin
        tick_cnt = '0;
        case (seq_phase)
          clnw_pkg::PH_RD1_HI: begin
            // D7 arrives on pin bit 3; it is the busy flag of the status byte.
            busy_flag = (({t.pin_data, 4'b0000} & clnw_pkg::BUSY_BIT) != 8'h00);
            if (busy_flag) busy_polls++;
            seq_phase = clnw_pkg::PH_RD1_LO;
          end
          clnw_pkg::PH_RD1_LO: seq_phase = clnw_pkg::PH_RD2_HI;
          clnw_pkg::PH_RD2_HI: seq_phase = clnw_pkg::PH_RD2_LO;
          clnw_pkg::PH_RD2_LO: begin
            if (busy_flag) seq_phase = clnw_pkg::PH_RD1_HI;
            else if (cur_low_only) seq_phase = clnw_pkg::PH_WRL_HI;
            else seq_phase = clnw_pkg::PH_WRH_HI;
          end
          clnw_pkg::PH_WRH_HI: seq_phase = clnw_pkg::PH_WRH_LO;
          clnw_pkg::PH_WRH_LO: seq_phase = clnw_pkg::PH_WRL_HI;
          clnw_pkg::PH_WRL_HI: seq_phase = clnw_pkg::PH_WRL_LO;
          default:             seq_phase = clnw_pkg::PH_IDLE;
        endcase
      end
    endfunction

    function void check_result(logic [clnw_pkg::OUT_DATA_W-1:0] d);
      clnw_pkg::pins_t got;
      clnw_pkg::pins_t want;
      got = '0;
      got.lcd_e     = d[0];
      got.lcd_rs    = d[1];
      got.lcd_rw    = d[2];
      got.bus_out   = d[6:3];
      got.bus_drive = d[7];
      got.ready_res = d[8];
      got.done_res  = d[9];
      if (pin_levels_q.size() == 0) begin
        note_failure($sformatf("result transfer 0x%h with no tick waiting", d));
        return;
      end
      want = pin_levels_q.pop_front();
      if (got !== want)
        note_failure($sformatf(
          {"exp e=%b rs=%b rw=%b bus=%h drv=%b rdy=%b done=%b, ",
           "got e=%b rs=%b rw=%b bus=%h drv=%b rdy=%b done=%b"},
          want.lcd_e, want.lcd_rs, want.lcd_rw, want.bus_out, want.bus_drive,
          want.ready_res, want.done_res, got.lcd_e, got.lcd_rs, got.lcd_rw,
          got.bus_out, got.bus_drive, got.ready_res, got.done_res));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // [0] req_valid, [8:1] req_byte, [9] req_low_only, [13:10] pin_data, [15:14] zero
  logic [clnw_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [0] req_rs
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [0] lcd_e, [1] lcd_rs, [2] lcd_rw, [6:3] bus_out, [7] bus_drive,
  // [8] ready_res, [9] done_res, [15:10] zero
  logic [clnw_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [clnw_pkg::STROBE_W-1:0]   cfg_data = '0;

  lcd_pin_scoreboard sb = new();

  // Pacing controls shared by the sender and the receiver.
  bit steady = 1'b0;        // no idling on either side while set
  bit hold_request = 1'b0;  // asks the receiver for one long hold-off
  int hold_left = 0;
  int cycle_count = 0;

  // Strobe lengths and tick counts of the random phases.
  logic [clnw_pkg::STROBE_W-1:0] phase_len[6] = '{10'd1, 10'd2, 10'd3, 10'd1, 10'd5, 10'd2};
  int unsigned phase_ticks[6] = '{180, 150, 150, 150, 120, 150};

  char_lcd_nibble_writer_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Both transfers are sampled at the rising edge. The result is checked
  // before the new tick is noted, so a result can never be paired with a
  // tick accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input('{req_valid:    s_axis_tdata[0],
                        req_byte:     s_axis_tdata[8:1],
                        req_rs:       s_axis_tuser,
                        req_low_only: s_axis_tdata[9],
                        pin_data:     s_axis_tdata[13:10]});
    end
  end

  // Receiver: random backpressure, none while steady, and one long hold-off
  // on request so the result register fills and the input stalls.
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("char_lcd_nibble_writer_core regression: fail");
      $finish;
    end
  end

  // Offers one tick, with random gaps in front of it, and returns at the
  // falling edge after the transfer. Valid is left high for the next call.
  task automatic send_tick(input clnw_pkg::tick_in_t t);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, t.pin_data, t.req_low_only, t.req_byte, t.req_valid};
    s_axis_tuser  <= t.req_rs;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic stop_ticks();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Only called with no transfer in flight.
  task automatic write_strobe(input logic [clnw_pkg::STROBE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_strobe(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random tick shaped by the predicted phase: mostly new requests when idle,
  // occasional ignored requests while busy, D7 set on about an eighth of ticks.
  function automatic clnw_pkg::tick_in_t random_tick();
    clnw_pkg::tick_in_t t;
    t.req_byte     = 8'($urandom_range(255));
    t.req_rs       = 1'($urandom_range(1));
    t.req_low_only = 1'($urandom_range(1));
    t.pin_data     = 4'($urandom_range(15));
    if ($urandom_range(3) != 0) t.pin_data[3] = 1'b0;
    if (sb.seq_phase == clnw_pkg::PH_IDLE) t.req_valid = ($urandom_range(99) < 80);
    else t.req_valid = ($urandom_range(99) < 25);
    return t;
  endfunction

  task automatic finish_sequence();
    while (sb.seq_phase != clnw_pkg::PH_IDLE) send_tick(random_tick());
  endtask

  // Full write with a given number of busy polls; a different request is
  // offered on every busy tick and must be ignored.
  task automatic directed_write(input logic [7:0] b, input logic rs, input logic lo,
                                input int polls);
    clnw_pkg::tick_in_t t;
    bit                 was_sampling;
    t = '{req_valid: 1'b1, req_byte: b, req_rs: rs, req_low_only: lo, pin_data: 4'h0};
    send_tick(t);
    t.req_byte = ~b;
    t.req_rs = ~rs;
    t.req_low_only = ~lo;
    while (sb.seq_phase != clnw_pkg::PH_IDLE) begin
      t.pin_data = (polls > 0) ? 4'hF : 4'h7;
      was_sampling = (sb.seq_phase == clnw_pkg::PH_RD1_HI);
      send_tick(t);
      if (was_sampling && sb.seq_phase != clnw_pkg::PH_RD1_HI && polls > 0) polls--;
    end
  endtask

  initial begin
    clnw_pkg::tick_in_t t;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset strobe length: start a write, then cut the strobe length to one
    // while E is high, with the count already past the new length.
    t = '{req_valid: 1'b1, req_byte: 8'hFF, req_rs: 1'b1, req_low_only: 1'b0,
          pin_data: 4'hF};
    send_tick(t);
    t = '{req_valid: 1'b1, req_byte: 8'h00, req_rs: 1'b0, req_low_only: 1'b1,
          pin_data: 4'h0};
    repeat (10) send_tick(t);
    stop_ticks();
    drain();
    write_strobe(10'd1);
    finish_sequence();

    // Byte and flag extremes, with zero, one and two busy polls.
    directed_write(8'h00, 1'b0, 1'b0, 1);
    directed_write(8'hFF, 1'b1, 1'b1, 0);
    directed_write(8'h5A, 1'b1, 1'b0, 2);
    stop_ticks();
    drain();

    // Longest strobe, then a zero length written mid-strobe, which counts
    // as one tick and ends the running period at once.
    write_strobe(10'd1023);
    t = '{req_valid: 1'b1, req_byte: 8'hC3, req_rs: 1'b0, req_low_only: 1'b0,
          pin_data: 4'h0};
    send_tick(t);
    repeat (20) send_tick(random_tick());
    stop_ticks();
    drain();
    write_strobe(10'd0);
    finish_sequence();
    stop_ticks();
    drain();

    // Random phases: the second one holds the receiver off for a long
    // stretch, the third runs with no idling at all.
    for (int i = 0; i < 6; i++) begin
      write_strobe(phase_len[i]);
      if (i == 1) hold_request = 1'b1;
      steady = (i == 2);
      repeat (phase_ticks[i]) send_tick(random_tick());
      finish_sequence();
      stop_ticks();
      drain();
    end
    steady = 1'b0;

    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.pending() != 0)
      sb.note_failure($sformatf("%0d predicted ticks never came out", sb.pending()));

    $display("Ran %0d bus ticks: %0d LCD writes completed, %0d busy polls answered busy.",
             sb.ticks_seen, sb.writes_done, sb.busy_polls);
    $display("Strobe lengths 0 to 1023, mid-strobe length changes, a long output hold.");
    if (sb.failures == 0) begin
      $display("char_lcd_nibble_writer_core regression: pass");
    end else begin
      $display("%0d failures", sb.failures);
      $display("char_lcd_nibble_writer_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/clnw_pkg.sv
hw/rtl/clnw_seq.sv
hw/rtl/char_lcd_nibble_writer_core.sv
dv/tb_top.sv
